@@ rtl/slri_pkg.sv @@
// Package for the sorted list insert/remove core.
// Holds the request codes and the fixed field widths; no dependencies.
package slri_pkg;

    localparam int unsigned ENTRY_W     = 32;
    localparam int unsigned COUNT_OUT_W = 5;

    // Request kind carried by each input item.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

endpackage

@@ rtl/slri_req_if.sv @@
// Request channel of the sorted list core: valid/ready plus the request payload.
// Depends on slri_pkg.
interface slri_req_if;
    import slri_pkg::*;

    logic                      valid;
    logic                      ready;
    t_op                       operation;
    logic signed [ENTRY_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ rtl/slri_rsp_if.sv @@
// Result channel of the sorted list core: valid/ready plus the result payload.
// Depends on slri_pkg.
interface slri_rsp_if;
    import slri_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      is_empty;
    logic                      is_full;
    logic signed [ENTRY_W-1:0] largest;

    modport source (output valid, output ok, output entry_count, output is_empty,
                    output is_full, output largest, input ready);
    modport sink   (input valid, input ok, input entry_count, input is_empty,
                    input is_full, input largest, output ready);
endinterface

@@ rtl/sorted_list_insert_remove_core.sv @@
// Sorted list insert/remove core: top level with the entry memory and its sequencer.
// Depends on slri_pkg, slri_req_if and slri_rsp_if.
//
//   Channel  Dir  Payload                                          Handshake
//   i_req    in   operation, value                                 valid/ready
//   o_rsp    out  ok, entry_count, is_empty, is_full, largest      valid/ready
//
// One request at a time: i_req.ready is high only when idle, the cycle after a result is taken.
// The memory read is registered, so every entry read or moved takes an ISSUE and an EVAL state.
// An insert moves each larger entry up one place; a full list refuses it without a walk. A
// remove reads entries upward until it passes the value or reaches the end, moving the tail
// down over the first equal entry. Every request then fetches the largest entry to report.
// Reset empties the list; the memory is not cleared.
module sorted_list_insert_remove_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    slri_req_if.sink          i_req,
    slri_rsp_if.source        o_rsp
);
    import slri_pkg::*;

    // Index width addresses the memory; count width also holds CAPACITY itself.
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // Sequencer states. ISSUE drives a memory address, EVAL sees the read data
    // and uses the shared comparator, TOP_RD/TOP_EV fetch the largest entry.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ISSUE  = 6'b000010,
        S_EVAL   = 6'b000100,
        S_TOP_RD = 6'b001000,
        S_TOP_EV = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_idx,   n_idx;
    t_op                        r_op;
    logic signed [ENTRY_W-1:0]  r_value;
    logic                       r_shift, n_shift;
    logic                       r_ok,    n_ok;
    logic signed [ENTRY_W-1:0]  r_largest, n_largest;

    // Entry memory, written at one address and read at one address per cycle.
    logic [ENTRY_W-1:0]         r_mem [CAPACITY];
    logic [ENTRY_W-1:0]         r_rd_data;

    logic                       w_accept;
    logic                       w_we;
    logic [IW-1:0]              w_wr_addr;
    logic [ENTRY_W-1:0]         w_wr_data;
    logic [IW-1:0]              w_rd_addr;
    logic [CW-1:0]              w_idx_dec;
    logic [CW-1:0]              w_count_dec;
    logic                       w_lt;
    logic                       w_eq;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_idx_dec   = r_idx - 1'b1;
    assign w_count_dec = r_count - 1'b1;

    // The one shared comparator: signed less-than plus equality against the request.
    assign w_lt = $signed(r_rd_data) < r_value;
    assign w_eq = r_rd_data == r_value;

    // Inserts walk down from the top, so they read one below the hole; removes
    // walk up and read at the index. The largest entry sits at count - 1.
    always_comb begin
        if (r_state == S_TOP_RD) begin
            w_rd_addr = w_count_dec[IW-1:0];
        end else if (r_op == OP_INSERT) begin
            w_rd_addr = w_idx_dec[IW-1:0];
        end else begin
            w_rd_addr = r_idx[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_shift   = r_shift;
        n_ok      = r_ok;
        n_largest = r_largest;
        w_we      = 1'b0;
        w_wr_addr = r_idx[IW-1:0];
        w_wr_data = r_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ok    = 1'b0;
                    n_shift = 1'b0;
                    if (i_req.operation == OP_INSERT) begin
                        n_idx = r_count;
                        // A full list refuses the insert and goes straight to fetching the largest entry.
                        n_state = (r_count == CW'(CAPACITY)) ? S_TOP_RD : S_ISSUE;
                    end else begin
                        n_idx   = '0;
                        n_state = S_ISSUE;
                    end
                end
            end

            S_ISSUE: begin
                if (r_op == OP_INSERT) begin
                    if (r_idx == '0) begin
                        // Every held entry was larger: the value goes to the bottom.
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                        n_ok    = 1'b1;
                        n_state = S_TOP_RD;
                    end else begin
                        n_state = S_EVAL;
                    end
                end else if (r_idx == r_count) begin
                    if (r_shift) begin
                        // Tail has been moved down over the removed entry.
                        n_count = w_count_dec;
                        n_ok    = 1'b1;
                    end
                    n_state = S_TOP_RD;
                end else begin
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                if (r_op == OP_INSERT) begin
                    w_we = 1'b1;
                    if (!w_lt && !w_eq) begin
                        // Larger entry moves up into the hole; the hole moves down.
                        w_wr_data = r_rd_data;
                        n_idx     = w_idx_dec;
                        n_state   = S_ISSUE;
                    end else begin
                        // Equal entries stay below the new value.
                        n_count = r_count + 1'b1;
                        n_ok    = 1'b1;
                        n_state = S_TOP_RD;
                    end
                end else if (r_shift) begin
                    w_we      = 1'b1;
                    w_wr_addr = w_idx_dec[IW-1:0];
                    w_wr_data = r_rd_data;
                    n_idx     = r_idx + 1'b1;
                    n_state   = S_ISSUE;
                end else if (w_lt) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_ISSUE;
                end else if (w_eq) begin
                    // First equal entry found; start moving the entries above it down over it.
                    n_idx   = r_idx + 1'b1;
                    n_shift = 1'b1;
                    n_state = S_ISSUE;
                end else begin
                    // Passed the place the value would be: it is not held.
                    n_state = S_TOP_RD;
                end
            end

            S_TOP_RD: begin
                if (r_count == '0) begin
                    n_largest = '0;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_TOP_EV;
                end
            end

            S_TOP_EV: begin
                n_largest = $signed(r_rd_data);
                n_state   = S_OUT;
            end

            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_shift <= 1'b0;
            r_op    <= OP_INSERT;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            if (w_accept) begin
                r_op <= i_req.operation;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_req.value;
        end
        r_ok      <= n_ok;
        r_largest <= n_largest;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_OUT);
    assign o_rsp.ok          = r_ok;
    assign o_rsp.entry_count = COUNT_OUT_W'(r_count);
    assign o_rsp.is_empty    = (r_count == '0);
    assign o_rsp.is_full     = (r_count == CW'(CAPACITY));
    assign o_rsp.largest     = r_largest;

`ifndef ASSERT_OFF
    // The count can never pass the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // The memory is only written while a request is being worked on.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT || r_state == S_TOP_EV) |-> !w_we)
        else $error("entry memory written outside request processing");

    // A new request is never taken while a result is offered.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request accepted while a result is pending");

    // A successful request changes the count by exactly one; this check only looks for a change.
    a_ok_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) && o_rsp.ok |->
            (r_count != $past(r_count, 1) || r_count != $past(r_count, 2)
             || r_count != $past(r_count, 3)))
        else $error("successful request left the count unchanged");

    // An empty list reports a largest entry of zero.
    a_empty_largest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.is_empty |-> o_rsp.largest == '0)
        else $error("empty list reports a nonzero largest entry");
`endif

endmodule

@@ dv/sorted_list_insert_remove_core_test.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_list_insert_remove_core: directed corner cases, a fill and drain,
// random insert/remove traffic with random idling on both channels, long result stalls and a
// back-to-back stretch. Depends on slri_pkg, slri_req_if, slri_rsp_if and the core itself.
module sorted_list_insert_remove_core_test;
    import slri_pkg::*;

    localparam int unsigned CAPACITY       = 16;
    localparam int unsigned LONG_HOLD      = 250;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned TAIL_CYCLES    = 100;
    localparam int unsigned MAX_REPORTS    = 10;

    localparam logic signed [ENTRY_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ENTRY_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                      ok;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      is_empty;
        logic                      is_full;
        logic signed [ENTRY_W-1:0] largest;
    } t_outcome;

    logic clk;
    logic rst_n;

    slri_req_if req_ch ();
    slri_rsp_if rsp_ch ();

    sorted_list_insert_remove_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Shadow copy of the list, kept in ascending order.
    logic signed [ENTRY_W-1:0] held [CAPACITY];
    int unsigned               held_count;

    t_outcome    outcomes_due[$];
    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned n_insert;
    int unsigned n_remove;
    int unsigned n_refused;
    int unsigned n_full_seen;
    int unsigned n_empty_seen;

    // Receiver controls: a one-shot long hold and a mode with no idling at all.
    bit long_hold_req;
    bit steady;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one request to the shadow list and returns the result it should give.
    function automatic t_outcome apply_request(input t_op op,
                                               input logic signed [ENTRY_W-1:0] val);
        t_outcome    res;
        int unsigned pos;
        int unsigned i;
        res.ok = 1'b0;
        pos    = 0;
        if (op == OP_INSERT) begin
            n_insert++;
            if (held_count < CAPACITY) begin
                // Equal entries stay in front of the new one.
                while (pos < held_count && held[pos] <= val) pos++;
                for (i = held_count; i > pos; i--) held[i] = held[i-1];
                held[pos] = val;
                held_count++;
                res.ok = 1'b1;
            end
        end else begin
            n_remove++;
            while (pos < held_count && held[pos] < val) pos++;
            if (pos < held_count && held[pos] == val) begin
                for (i = pos + 1; i < held_count; i++) held[i-1] = held[i];
                held_count--;
                res.ok = 1'b1;
            end
        end
        if (!res.ok) n_refused++;
        res.entry_count = held_count[COUNT_OUT_W-1:0];
        res.is_empty    = (held_count == 0);
        res.is_full     = (held_count == CAPACITY);
        res.largest     = (held_count == 0) ? '0 : held[held_count-1];
        if (res.is_full) n_full_seen++;
        if (res.is_empty) n_empty_seen++;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Removes mostly hit a held entry; inserts favor a narrow band so duplicates pile up.
    function automatic logic signed [ENTRY_W-1:0] pick_value(input t_op op);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (held_count != 0 && ((op == OP_REMOVE && r < 70) || (op == OP_INSERT && r < 20)))
            return held[$urandom_range(0, held_count - 1)];
        r = $urandom_range(0, 99);
        if (r < 55) return ENTRY_W'(int'($urandom_range(0, 16)) - 8);
        if (r < 75) begin
            case ($urandom_range(0, 5))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 1;
                3: return VAL_MAX - 1;
                4: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // Offers one item after an optional gap and waits until the core takes it.
    // Valid is left high afterwards; the next call or a pause decides its level.
    task automatic send_request(input t_op op, input logic signed [ENTRY_W-1:0] val,
                                input int unsigned gap);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= val;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        outcomes_due.push_back(apply_request(op, val));
    endtask

    // Sender pause: nothing offered until every outstanding result has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outcomes_due.size() != 0);
    endtask

    task automatic test_directed_corners();
        send_request(OP_REMOVE, 32'sd5, 0);     // remove from the empty list
        send_request(OP_INSERT, VAL_MIN, 0);
        send_request(OP_INSERT, VAL_MAX, 1);
        send_request(OP_INSERT, 32'sd0, 0);
        send_request(OP_INSERT, -32'sd1, 2);
        send_request(OP_INSERT, 32'sd5, 0);
        send_request(OP_INSERT, 32'sd5, 0);     // duplicate goes after its twin
        send_request(OP_REMOVE, 32'sd5, 0);
        send_request(OP_REMOVE, 32'sd6, 0);     // value not present
        send_request(OP_REMOVE, VAL_MAX, 3);    // largest drops back to 5
        send_request(OP_REMOVE, VAL_MIN, 0);
        send_request(OP_REMOVE, 32'sd0, 0);
        send_request(OP_REMOVE, -32'sd1, 0);
        send_request(OP_REMOVE, 32'sd5, 0);     // list is empty again
        send_request(OP_REMOVE, 32'sd5, 0);
        wait_drained();
    endtask

    // Fills the list with a narrow spread of values, pushes on it while full,
    // then empties it again in random order.
    task automatic test_fill_and_drain();
        logic signed [ENTRY_W-1:0] val;
        while (held_count < CAPACITY)
            send_request(OP_INSERT, ENTRY_W'(int'($urandom_range(0, 6)) - 3), pick_gap());
        send_request(OP_INSERT, 32'sd0, 0);     // insert into the full list
        send_request(OP_INSERT, VAL_MAX, 0);
        send_request(OP_REMOVE, 32'sd100, 0);   // absent value while full
        while (held_count != 0) begin
            val = held[$urandom_range(0, held_count - 1)];
            send_request(OP_REMOVE, val, pick_gap());
        end
        wait_drained();
    endtask

    // Random traffic; the insert share changes every few dozen items so the list
    // wanders between empty and full.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned k;
        int unsigned insert_pct;
        t_op         op;
        insert_pct = 50;
        for (k = 0; k < n_items; k++) begin
            if (k % 48 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 20;
                    1: insert_pct = 50;
                    default: insert_pct = 80;
                endcase
            end
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            send_request(op, pick_value(op), pick_gap());
        end
        wait_drained();
    endtask

    // The receiver stops for a long stretch while the sender keeps offering items,
    // so the core backs up onto its request side.
    task automatic test_result_backpressure();
        int unsigned k;
        t_op         op;
        long_hold_req = 1'b1;
        for (k = 0; k < 12; k++) begin
            op = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_REMOVE;
            send_request(op, pick_value(op), 0);
        end
        wait_drained();
    endtask

    // A stretch with neither side idling.
    task automatic test_back_to_back();
        int unsigned k;
        t_op         op;
        steady = 1'b1;
        for (k = 0; k < 40; k++) begin
            op = ($urandom_range(0, 2) != 0) ? OP_INSERT : OP_REMOVE;
            send_request(op, pick_value(op), 0);
        end
        wait_drained();
        steady = 1'b0;
    endtask

    // Result-side ready: random runs and gaps, a long hold on request, or always on.
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned run_left;
        hold_left = 0;
        run_left  = 0;
        forever begin
            @(posedge clk);
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end else if (steady) begin
                rsp_ch.ready <= 1'b1;
            end else if (run_left != 0) begin
                run_left--;
                rsp_ch.ready <= 1'b1;
            end else begin
                hold_left = pick_gap();
                run_left  = $urandom_range(1, 12);
                if (hold_left != 0) begin
                    hold_left--;
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Compares every accepted result with the oldest outstanding expectation.
    always @(posedge clk) begin
        t_outcome want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (outcomes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: result with nothing outstanding: ok=%0b count=%0d",
                             rsp_ch.ok, rsp_ch.entry_count);
            end else begin
                want = outcomes_due.pop_front();
                results_checked++;
                if (rsp_ch.ok !== want.ok || rsp_ch.entry_count !== want.entry_count ||
                    rsp_ch.is_empty !== want.is_empty || rsp_ch.is_full !== want.is_full ||
                    rsp_ch.largest !== want.largest) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"ERROR: result %0d expected ok=%0b count=%0d",
                                  " empty=%0b full=%0b largest=%0d"},
                                 results_checked, want.ok, want.entry_count, want.is_empty,
                                 want.is_full, want.largest);
                        $display({"       got      ok=%0b count=%0d",
                                  " empty=%0b full=%0b largest=%0d"},
                                 rsp_ch.ok, rsp_ch.entry_count, rsp_ch.is_empty,
                                 rsp_ch.is_full, rsp_ch.largest);
                    end
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel moves an item.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", quiet);
                $display("sorted_list_insert_remove_core_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        rst_n            = 1'b0;
        held_count       = 0;
        mismatch_count   = 0;
        results_checked  = 0;
        n_insert         = 0;
        n_remove         = 0;
        n_refused        = 0;
        n_full_seen      = 0;
        n_empty_seen     = 0;
        long_hold_req    = 1'b0;
        steady           = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_fill_and_drain();
        test_random_traffic(400);
        test_result_backpressure();
        test_back_to_back();
        test_random_traffic(400);
        test_result_backpressure();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display({"Ran %0d inserts and %0d removes, %0d of them refused;",
                  " list full %0d times, empty %0d times."},
                 n_insert, n_remove, n_refused, n_full_seen, n_empty_seen);
        $display("Checked %0d results, %0d mismatches, %0d still outstanding.",
                 results_checked, mismatch_count, outcomes_due.size());
        if (mismatch_count == 0 && outcomes_due.size() == 0) begin
            $display("sorted_list_insert_remove_core_test: PASS");
        end else begin
            $display("sorted_list_insert_remove_core_test: FAIL");
        end
        $finish;
    end

endmodule

@@ sorted_list_insert_remove_core.f @@
rtl/slri_pkg.sv
rtl/slri_req_if.sv
rtl/slri_rsp_if.sv
rtl/sorted_list_insert_remove_core.sv
dv/sorted_list_insert_remove_core_test.sv
